[hw/rtl/ear_clipping_triangulator_assert.svh]
// Assertion macros for the ear clipping triangulator.
`ifndef EAR_CLIPPING_TRIANGULATOR_ASSERT_SVH
`define EAR_CLIPPING_TRIANGULATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define ECT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ECT_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ECT_ASSERT_IMP(label, clk, rst, ante, cons)
`define ECT_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

[hw/rtl/ect_pkg.sv]
// Shared types for the ear clipping triangulator.
package ect_pkg;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_LOAD = 2'd1,
    OP_NEXT = 2'd2,
    OP_HEAD = 2'd3
  } cell_op_t;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_ALIGN = 9'b000000010,
    S_CAND  = 9'b000000100,
    S_SCAN  = 9'b000001000,
    S_DRAIN = 9'b000010000,
    S_SWAP  = 9'b000100000,
    S_FINAL = 9'b001000000,
    S_FWAIT = 9'b010000000,
    S_FLUSH = 9'b100000000
  } state_t;

  typedef struct packed {
    logic vld;
    logic first;
    logic chk;
  } tag_t;

  localparam int ORIENT_LAT = 3;

endpackage

[hw/rtl/ect_cell.sv]
// One vertex cell of the rotating vertex ring.
module ect_cell #(
  parameter int W = 24
) (
  input  logic                clk,
  input  ect_pkg::cell_op_t   op,
  input  logic signed [W-1:0] ld_y,
  input  logic signed [W-1:0] ld_z,
  input  logic signed [W-1:0] nx_y,
  input  logic signed [W-1:0] nx_z,
  input  logic signed [W-1:0] hd_y,
  input  logic signed [W-1:0] hd_z,
  output logic signed [W-1:0] y,
  output logic signed [W-1:0] z
);

  always_ff @(posedge clk) begin
    case (op)
      ect_pkg::OP_LOAD: begin
        y <= ld_y;
        z <= ld_z;
      end
      ect_pkg::OP_NEXT: begin
        y <= nx_y;
        z <= nx_z;
      end
      ect_pkg::OP_HEAD: begin
        y <= hd_y;
        z <= hd_z;
      end
      default: begin
        y <= y;
        z <= z;
      end
    endcase
  end

endmodule

[hw/rtl/ect_orient.sv]
// Pipelined sign of cross(p - o, q - o): the differences, the products and the sign are each registered.
module ect_orient #(
  parameter int W = 24
) (
  input  logic                clk,
  input  logic signed [W-1:0] o_y,
  input  logic signed [W-1:0] o_z,
  input  logic signed [W-1:0] p_y,
  input  logic signed [W-1:0] p_z,
  input  logic signed [W-1:0] q_y,
  input  logic signed [W-1:0] q_z,
  output logic                neg,
  output logic                pos
);

  logic signed [W:0]     uy, uz, wy, wz;
  logic signed [2*W+1:0] m1, m2;
  logic        [2*W+2:0] d;

  assign d = {m1[2*W+1], m1} - {m2[2*W+1], m2};

  always_ff @(posedge clk) begin
    uy  <= {p_y[W-1], p_y} - {o_y[W-1], o_y};
    uz  <= {p_z[W-1], p_z} - {o_z[W-1], o_z};
    wy  <= {q_y[W-1], q_y} - {o_y[W-1], o_y};
    wz  <= {q_z[W-1], q_z} - {o_z[W-1], o_z};
    m1  <= uy * wz;
    m2  <= uz * wy;
    neg <= d[2*W+2];
    pos <= !d[2*W+2] && (|d);
  end

endmodule

[hw/rtl/ear_clipping_triangulator.sv]
// Ear clipping triangulator: vertices stream in one per cycle into a ring of
// vertex cells; the final vertex starts clipping if there are three or more.
// Each candidate corner is captured, then every vertex of the ring is rotated
// past three orientation units and the pipeline drains; the ring is realigned
// after every ear. The rotation of the ring through the orientation units sets
// the run time. No request is taken while a polygon is being clipped.
module ear_clipping_triangulator #(
  parameter int MAX_VERTICES = 32,
  parameter int COORD_BITS   = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]   s_tdata,   // vertex_y, vertex_z
  input  logic                                s_tlast,   // last_vertex
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [((6*COORD_BITS+7)/8)*8-1:0]   m_tdata,   // first_y, first_z,
                                                         // second_y, second_z,
                                                         // third_y, third_z
  output logic                                m_tuser,   // no_ear_fallback
  output logic                                m_tlast    // last_triangle
);

  `include "ear_clipping_triangulator_assert.svh"

  localparam int W   = COORD_BITS;
  localparam int CW  = $clog2(MAX_VERTICES + 1);
  localparam int IW  = $clog2(MAX_VERTICES);
  localparam int OW  = ((6*COORD_BITS+7)/8)*8;

  ect_pkg::state_t   state;
  ect_pkg::cell_op_t cop [MAX_VERTICES];
  ect_pkg::tag_t     tg [ect_pkg::ORIENT_LAT];
  ect_pkg::tag_t     tg_in;

  logic signed [W-1:0] cy [MAX_VERTICES];
  logic signed [W-1:0] cz [MAX_VERTICES];
  logic signed [W-1:0] in_y, in_z;
  logic signed [W-1:0] ta_y, ta_z, tb_y, tb_z, tc_y, tc_z;
  logic signed [W-1:0] u0_oy, u0_oz, u0_py, u0_pz, u0_qy, u0_qz;
  logic [6*W-1:0] pend;
  logic           pend_vld;
  logic [CW-1:0]  count, cnt_after, n, n_m1, t, tgt;
  logic [IW-1:0]  h, i;
  logic           fin, fall, cvx, enclosed, fpos;
  logic           neg0, neg1, neg2, pos0, pos1, pos2;
  logic           accept, tg_none, slot_free, ear, rot, rem, swap_go, push;
  logic           cpush;
  logic [OW-1:0]  push_data;
  logic           push_user, push_last;

  assign in_y      = s_tdata[W-1:0];
  assign in_z      = s_tdata[2*W-1:W];
  assign s_tready  = (state == ect_pkg::S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign cnt_after = (count < CW'(MAX_VERTICES)) ? count + CW'(1) : count;
  assign n_m1      = n - CW'(1);
  assign tgt       = (n > CW'(3)) ? n_m1 : '0;
  assign tg_none   = !(tg[0].vld || tg[1].vld || tg[2].vld);
  assign slot_free = !m_tvalid || m_tready;
  assign ear       = cvx && !enclosed;
  assign swap_go   = !pend_vld || slot_free;

  assign rot = ((state == ect_pkg::S_ALIGN) && (CW'(h) != tgt)) ||
               (state == ect_pkg::S_SCAN) ||
               ((state == ect_pkg::S_DRAIN) && tg_none && !ear && (CW'(i) != n_m1));
  assign rem = (state == ect_pkg::S_SWAP) && swap_go && !fin;

  // per-cell command decode
  always_comb begin
    for (int k = 0; k < MAX_VERTICES; k++) begin
      cop[k] = ect_pkg::OP_HOLD;
      if (accept && (count < CW'(MAX_VERTICES)) && (count == CW'(k))) begin
        cop[k] = ect_pkg::OP_LOAD;
      end else if (rot) begin
        if (CW'(k) < n_m1) cop[k] = ect_pkg::OP_NEXT;
        else if (CW'(k) == n_m1) cop[k] = ect_pkg::OP_HEAD;
      end else if (rem) begin
        if (k >= 1 && CW'(k) < n_m1) cop[k] = ect_pkg::OP_NEXT;
      end
    end
  end

  for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
    if (g == MAX_VERTICES - 1) begin : g_end
      ect_cell #(.W(W)) u_cell (
        .clk(clk), .op(cop[g]), .ld_y(in_y), .ld_z(in_z),
        .nx_y(cy[0]), .nx_z(cz[0]), .hd_y(cy[0]), .hd_z(cz[0]),
        .y(cy[g]), .z(cz[g])
      );
    end else begin : g_mid
      ect_cell #(.W(W)) u_cell (
        .clk(clk), .op(cop[g]), .ld_y(in_y), .ld_z(in_z),
        .nx_y(cy[g+1]), .nx_z(cz[g+1]), .hd_y(cy[0]), .hd_z(cz[0]),
        .y(cy[g]), .z(cz[g])
      );
    end
  end

  // unit 0: orient(a, b, j); in the closing test orient(v1, v0, v2)
  always_comb begin
    if (state == ect_pkg::S_FINAL) begin
      u0_oy = cy[1]; u0_oz = cz[1];
      u0_py = cy[0]; u0_pz = cz[0];
      u0_qy = cy[2]; u0_qz = cz[2];
    end else begin
      u0_oy = ta_y;  u0_oz = ta_z;
      u0_py = tb_y;  u0_pz = tb_z;
      u0_qy = cy[0]; u0_qz = cz[0];
    end
  end

  ect_orient #(.W(W)) u_or0 (
    .clk(clk), .o_y(u0_oy), .o_z(u0_oz), .p_y(u0_py), .p_z(u0_pz),
    .q_y(u0_qy), .q_z(u0_qz), .neg(neg0), .pos(pos0)
  );
  ect_orient #(.W(W)) u_or1 (
    .clk(clk), .o_y(tc_y), .o_z(tc_z), .p_y(ta_y), .p_z(ta_z),
    .q_y(cy[0]), .q_z(cz[0]), .neg(neg1), .pos(pos1)
  );
  ect_orient #(.W(W)) u_or2 (
    .clk(clk), .o_y(tb_y), .o_z(tb_z), .p_y(tc_y), .p_z(tc_z),
    .q_y(cy[0]), .q_z(cz[0]), .neg(neg2), .pos(pos2)
  );

  // first cell of a scan is the previous corner itself: convexity test;
  // the three ring slots c, a, b are never containment candidates
  always_comb begin
    tg_in = '0;
    if (state == ect_pkg::S_SCAN) begin
      tg_in.vld   = 1'b1;
      tg_in.first = (t == '0);
      tg_in.chk   = (t >= CW'(3));
    end else if (state == ect_pkg::S_FINAL) begin
      tg_in.vld   = 1'b1;
      tg_in.first = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ect_pkg::ORIENT_LAT; k++) tg[k] <= '0;
    end else begin
      tg[0] <= tg_in;
      for (int k = 1; k < ect_pkg::ORIENT_LAT; k++) tg[k] <= tg[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ect_pkg::S_CAND) begin
      cvx      <= 1'b0;
      enclosed <= 1'b0;
    end else if (tg[2].vld) begin
      if (tg[2].first) begin
        cvx  <= neg0;
        fpos <= pos0;
      end
      if (tg[2].chk && neg0 && neg1 && neg2) enclosed <= 1'b1;
    end
  end

  always_comb begin
    push      = 1'b0;
    push_data = '0;
    push_user = 1'b0;
    push_last = 1'b0;
    if ((state == ect_pkg::S_SWAP) && pend_vld && slot_free) begin
      push      = 1'b1;
      push_data = OW'(pend);
    end else if ((state == ect_pkg::S_FLUSH) && slot_free) begin
      if (pend_vld) begin
        push      = 1'b1;
        push_data = OW'(pend);
        push_last = !fall;
      end else if (fall) begin
        push      = 1'b1;
        push_user = 1'b1;
        push_last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      m_tdata <= push_data;
      m_tuser <= push_user;
      m_tlast <= push_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ect_pkg::S_IDLE;
      count    <= '0;
      pend_vld <= 1'b0;
      fin      <= 1'b0;
      fall     <= 1'b0;
    end else begin
      case (state)
        ect_pkg::S_IDLE: begin
          if (accept) begin
            if (s_tlast) begin
              count <= '0;
              n     <= cnt_after;
              h     <= '0;
              i     <= '0;
              if (cnt_after >= CW'(3)) state <= ect_pkg::S_ALIGN;
            end else begin
              count <= cnt_after;
            end
          end
        end
        ect_pkg::S_ALIGN: begin
          if (CW'(h) == tgt) begin
            state <= (n > CW'(3)) ? ect_pkg::S_CAND : ect_pkg::S_FINAL;
          end else begin
            h <= (CW'(h) == n_m1) ? '0 : h + IW'(1);
          end
        end
        ect_pkg::S_CAND: begin
          tc_y  <= cy[0]; tc_z <= cz[0];
          ta_y  <= cy[1]; ta_z <= cz[1];
          tb_y  <= cy[2]; tb_z <= cz[2];
          t     <= '0;
          state <= ect_pkg::S_SCAN;
        end
        ect_pkg::S_SCAN: begin
          t <= t + CW'(1);
          if (t == n_m1) state <= ect_pkg::S_DRAIN;
        end
        ect_pkg::S_DRAIN: begin
          if (tg_none) begin
            if (ear) begin
              state <= ect_pkg::S_SWAP;
            end else if (CW'(i) == n_m1) begin
              fall  <= 1'b1;
              state <= ect_pkg::S_FLUSH;
            end else begin
              i     <= i + IW'(1);
              h     <= (CW'(h) == n_m1) ? '0 : h + IW'(1);
              state <= ect_pkg::S_CAND;
            end
          end
        end
        ect_pkg::S_SWAP: begin
          if (swap_go) begin
            pend     <= {tc_z, tc_y, tb_z, tb_y, ta_z, ta_y};
            pend_vld <= 1'b1;
            if (fin) begin
              state <= ect_pkg::S_FLUSH;
            end else begin
              n     <= n_m1;
              h     <= (i == '0) ? IW'(n - CW'(2)) : i - IW'(1);
              i     <= '0;
              state <= ect_pkg::S_ALIGN;
            end
          end
        end
        ect_pkg::S_FINAL: begin
          ta_y  <= cy[0]; ta_z <= cz[0];
          tb_y  <= cy[1]; tb_z <= cz[1];
          tc_y  <= cy[2]; tc_z <= cz[2];
          fin   <= 1'b1;
          state <= ect_pkg::S_FWAIT;
        end
        ect_pkg::S_FWAIT: begin
          if (tg_none) state <= fpos ? ect_pkg::S_SWAP : ect_pkg::S_FLUSH;
        end
        ect_pkg::S_FLUSH: begin
          if (pend_vld) begin
            if (slot_free) pend_vld <= 1'b0;
          end else if (fall) begin
            if (slot_free) fall <= 1'b0;
          end else begin
            fin   <= 1'b0;
            state <= ect_pkg::S_IDLE;
          end
        end
        default: state <= ect_pkg::S_IDLE;
      endcase
    end
  end

  assign cpush = push;

  `ECT_ASSERT_IMP(a_idle_pipe_empty, clk, rst, state == ect_pkg::S_IDLE, tg_none)
  `ECT_ASSERT_IMP(a_cand_n, clk, rst, state == ect_pkg::S_CAND, n > CW'(3))
  `ECT_ASSERT_IMP(a_push_room, clk, rst, cpush, !m_tvalid || m_tready)
  `ECT_ASSERT_IMP(a_fallback_last, clk, rst, m_tvalid && m_tuser, m_tlast)
  `ECT_ASSERT_NXT(a_last_to_idle, clk, rst, (state == ect_pkg::S_FLUSH) && !pend_vld && !fall, state == ect_pkg::S_IDLE)

endmodule
